>>> sv/go_to_goal_pi_controller_assert.svh
// Assertion macros for the go-to-goal PI controller.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GO_TO_GOAL_PI_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_PI_CONTROLLER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GTG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define GTG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/gtg_pkg.sv
// Shared types, constants and tables for the go-to-goal PI controller.
// No dependencies.
`default_nettype none
package gtg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ROOT_STEPS   = 17;
   localparam int LOOP_STEPS   = (CORDIC_STEPS > ROOT_STEPS) ? CORDIC_STEPS : ROOT_STEPS;
   localparam int ITER_W       = 5;

   localparam logic signed [17:0] PI_Q12     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
   localparam logic signed [20:0] PI_Q16     = 21'sd205887;

   typedef enum logic [2:0] {
      MUL_DX    = 3'd0,
      MUL_DY    = 3'd1,
      MUL_KP    = 3'd2,
      MUL_KI_LO = 3'd3,
      MUL_KI_HI = 3'd4,
      MUL_KH    = 3'd5
   } mul_sel_type;

   typedef enum logic [1:0] {
      REG_STANDOFF = 2'd0,
      REG_SPEED    = 2'd1,
      REG_INTEGRAL = 2'd2,
      REG_TURN     = 2'd3
   } reg_addr_type;

   typedef struct packed {
      logic              load_pose;
      logic              load_goal;
      logic              mul_en;
      logic              acc_add;
      mul_sel_type       mul_sel;
      logic              root_init;
      logic              iter_en;
      logic [ITER_W-1:0] iter_idx;
      logic              err_en;
      logic              wrap_en;
      logic              lin_en;
      logic              publish;
   } dp_cmd_type;

   typedef struct packed {
      logic herr_in_range;
   } dp_status_type;

   function automatic logic signed [20:0] atan_q16(input logic [ITER_W-1:0] idx);
      logic signed [20:0] v;
      case (idx)
         5'd0:    v = 21'sd51472;
         5'd1:    v = 21'sd30385;
         5'd2:    v = 21'sd16055;
         5'd3:    v = 21'sd8150;
         5'd4:    v = 21'sd4091;
         5'd5:    v = 21'sd2047;
         5'd6:    v = 21'sd1024;
         5'd7:    v = 21'sd512;
         5'd8:    v = 21'sd256;
         5'd9:    v = 21'sd128;
         5'd10:   v = 21'sd64;
         5'd11:   v = 21'sd32;
         5'd12:   v = 21'sd16;
         5'd13:   v = 21'sd8;
         5'd14:   v = 21'sd4;
         5'd15:   v = 21'sd2;
         5'd16:   v = 21'sd1;
         default: v = 21'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> sv/gtg_dp.sv
// Datapath: pose store, squared distance, shift-subtract root, CORDIC,
// error sum and shared multiplier. Depends on gtg_pkg.
`default_nettype none
module gtg_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gtg_pkg::dp_cmd_type   cmd,
   output gtg_pkg::dp_status_type     status,
   input  wire logic signed [15:0]    req_pos_x,
   input  wire logic signed [15:0]    req_pos_y,
   input  wire logic signed [14:0]    req_heading,
   input  wire logic [14:0]           standoff_distance,
   input  wire logic [15:0]           speed_gain,
   input  wire logic [15:0]           integral_gain,
   input  wire logic [15:0]           turn_gain,
   output logic signed [15:0]         rsp_linear_speed,
   output logic signed [15:0]         rsp_turn_rate
);

   logic signed [15:0] own_x_ff, own_y_ff, own_hd_ff;
   logic signed [16:0] dx_ff, dy_ff, dx_c, dy_c;
   logic               zero_ff;
   logic signed [19:0] cx_ff, cy_ff, cx_in, cy_in, xs, ys;
   logic signed [20:0] cz_ff, cz_in, z_round;
   logic signed [51:0] acc_ff, acc_in, addend;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod;
   logic [33:0]        n_ff, r_ff, bit_ff, n_in, r_in, bit_in, trial;
   logic signed [17:0] e_ff, e_in, herr_ff, herr_in, bearing;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [32:0] sum_wide;
   logic signed [15:0] lin_ff, rsp_lin_ff, rsp_turn_ff;

   function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
      logic signed [15:0] r;
      if (v > 52'sd32767) r = 16'sh7fff;
      else if (v < -52'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   assign dx_c = {req_pos_x[15], req_pos_x} - {own_x_ff[15], own_x_ff};
   assign dy_c = {req_pos_y[15], req_pos_y} - {own_y_ff[15], own_y_ff};

   always_comb begin
      mul_a = 18'sd0;
      mul_b = 18'sd0;
      case (cmd.mul_sel)
         gtg_pkg::MUL_DX: begin
            mul_a = {dx_ff[16], dx_ff};
            mul_b = {dx_ff[16], dx_ff};
         end
         gtg_pkg::MUL_DY: begin
            mul_a = {dy_ff[16], dy_ff};
            mul_b = {dy_ff[16], dy_ff};
         end
         gtg_pkg::MUL_KP: begin
            mul_a = e_ff;
            mul_b = $signed({2'b00, speed_gain});
         end
         gtg_pkg::MUL_KI_LO: begin
            mul_a = $signed({2'b00, sum_ff[15:0]});
            mul_b = $signed({2'b00, integral_gain});
         end
         gtg_pkg::MUL_KI_HI: begin
            mul_a = {{2{sum_ff[31]}}, sum_ff[31:16]};
            mul_b = $signed({2'b00, integral_gain});
         end
         gtg_pkg::MUL_KH: begin
            mul_a = herr_ff;
            mul_b = $signed({2'b00, turn_gain});
         end
         default: begin
            mul_a = 18'sd0;
            mul_b = 18'sd0;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign addend = (cmd.mul_sel == gtg_pkg::MUL_KI_HI) ? {prod, 16'b0}
                                                       : {{16{prod[35]}}, prod};
   assign acc_in = cmd.acc_add ? acc_ff + addend : addend;

   // one root bit per step
   always_comb begin
      trial  = r_ff + bit_ff;
      n_in   = n_ff;
      r_in   = r_ff >> 1;
      bit_in = bit_ff >> 2;
      if (n_ff >= trial) begin
         n_in = n_ff - trial;
         r_in = (r_ff >> 1) + bit_ff;
      end
   end

   // one CORDIC micro-rotation per step
   always_comb begin
      xs = cx_ff >>> cmd.iter_idx;
      ys = cy_ff >>> cmd.iter_idx;
      if (!cy_ff[19]) begin
         cx_in = cx_ff + ys;
         cy_in = cy_ff - xs;
         cz_in = cz_ff + gtg_pkg::atan_q16(cmd.iter_idx);
      end else begin
         cx_in = cx_ff - ys;
         cy_in = cy_ff + xs;
         cz_in = cz_ff - gtg_pkg::atan_q16(cmd.iter_idx);
      end
   end

   assign z_round  = (cz_ff + 21'sd8) >>> 4;
   assign bearing  = zero_ff ? 18'sd0 : z_round[17:0];
   assign e_in     = $signed({1'b0, r_ff[16:0]}) - $signed({3'b000, standoff_distance});
   assign herr_in  = bearing - {{3{own_hd_ff[14]}}, own_hd_ff[14:0]};
   assign sum_wide = {sum_ff[31], sum_ff} + {{15{e_in[17]}}, e_in};

   always_comb begin
      if (sum_wide > 33'sh0_7fff_ffff) sum_in = 32'sh7fff_ffff;
      else if (sum_wide < -33'sh0_8000_0000) sum_in = 32'sh8000_0000;
      else sum_in = sum_wide[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff  <= '0;
         own_y_ff  <= '0;
         own_hd_ff <= '0;
         sum_ff    <= '0;
      end else begin
         if (cmd.load_pose) begin
            own_x_ff  <= req_pos_x;
            own_y_ff  <= req_pos_y;
            own_hd_ff <= {req_heading[14], req_heading};
         end
         if (cmd.err_en) sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_goal) begin
         dx_ff   <= dx_c;
         dy_ff   <= dy_c;
         zero_ff <= (dx_c == 17'sd0) && (dy_c == 17'sd0);
         if (dx_c[16]) begin
            cx_ff <= -{{3{dx_c[16]}}, dx_c};
            cy_ff <= -{{3{dy_c[16]}}, dy_c};
            cz_ff <= dy_c[16] ? -gtg_pkg::PI_Q16 : gtg_pkg::PI_Q16;
         end else begin
            cx_ff <= {{3{dx_c[16]}}, dx_c};
            cy_ff <= {{3{dy_c[16]}}, dy_c};
            cz_ff <= 21'sd0;
         end
      end else if (cmd.iter_en && (cmd.iter_idx < gtg_pkg::ITER_W'(gtg_pkg::CORDIC_STEPS))) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
      if (cmd.mul_en) acc_ff <= acc_in;
      if (cmd.root_init) begin
         n_ff   <= acc_ff[33:0];
         r_ff   <= '0;
         bit_ff <= 34'h1_0000_0000;
      end else if (cmd.iter_en && (cmd.iter_idx < gtg_pkg::ITER_W'(gtg_pkg::ROOT_STEPS))) begin
         n_ff   <= n_in;
         r_ff   <= r_in;
         bit_ff <= bit_in;
      end
      if (cmd.err_en) begin
         e_ff    <= e_in;
         herr_ff <= herr_in;
      end else if (cmd.wrap_en) begin
         if (herr_ff > gtg_pkg::PI_Q12) herr_ff <= herr_ff - gtg_pkg::TWO_PI_Q12;
         else herr_ff <= herr_ff + gtg_pkg::TWO_PI_Q12;
      end
      if (cmd.lin_en) lin_ff <= sat16((acc_ff + 52'sd8192) >>> 14);
      if (cmd.publish) begin
         rsp_lin_ff  <= lin_ff;
         rsp_turn_ff <= sat16((acc_ff + 52'sd131072) >>> 18);
      end
   end

   assign status.herr_in_range = (herr_ff <= gtg_pkg::PI_Q12) && (herr_ff >= -gtg_pkg::PI_Q12);
   assign rsp_linear_speed     = rsp_lin_ff;
   assign rsp_turn_rate        = rsp_turn_ff;

endmodule
`default_nettype wire

>>> sv/gtg_ctrl.sv
// Controller state machine: sequences one request through the datapath
// and owns the result valid flag. Depends on gtg_pkg and the assert header.
`default_nettype none
`include "go_to_goal_pi_controller_assert.svh"
module gtg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_op,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output gtg_pkg::dp_cmd_type         cmd,
   input  wire gtg_pkg::dp_status_type status
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_SQX   = 13'b0000000000010,
      ST_SQY   = 13'b0000000000100,
      ST_RINIT = 13'b0000000001000,
      ST_ITER  = 13'b0000000010000,
      ST_ERR   = 13'b0000000100000,
      ST_WRAP  = 13'b0000001000000,
      ST_MKP   = 13'b0000010000000,
      ST_MKILO = 13'b0000100000000,
      ST_MKIHI = 13'b0001000000000,
      ST_LIN   = 13'b0010000000000,
      ST_MKH   = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [gtg_pkg::ITER_W-1:0]    cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = gtg_pkg::MUL_DX;
      cmd.iter_idx = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op) begin
                  cmd.load_goal = 1'b1;
                  state_in      = ST_SQX;
               end else begin
                  cmd.load_pose = 1'b1;
               end
            end
         end
         ST_SQX: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SQY;
         end
         ST_SQY: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_add = 1'b1;
            cmd.mul_sel = gtg_pkg::MUL_DY;
            state_in    = ST_RINIT;
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter_en = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == gtg_pkg::ITER_W'(gtg_pkg::LOOP_STEPS - 1)) state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_WRAP;
         end
         ST_WRAP: begin
            if (status.herr_in_range) state_in = ST_MKP;
            else cmd.wrap_en = 1'b1;
         end
         ST_MKP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = gtg_pkg::MUL_KP;
            state_in    = ST_MKILO;
         end
         ST_MKILO: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_add = 1'b1;
            cmd.mul_sel = gtg_pkg::MUL_KI_LO;
            state_in    = ST_MKIHI;
         end
         ST_MKIHI: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_add = 1'b1;
            cmd.mul_sel = gtg_pkg::MUL_KI_HI;
            state_in    = ST_LIN;
         end
         ST_LIN: begin
            cmd.lin_en = 1'b1;
            state_in   = ST_MKH;
         end
         ST_MKH: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = gtg_pkg::MUL_KH;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            cmd.mul_sel = gtg_pkg::MUL_KH;
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GTG_ASSERT_SAME(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `GTG_ASSERT_NEXT(a_goal_starts, clock, reset, accept && req_op, state_ff == ST_SQX, "goal request did not start")
   `GTG_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid_ff, "published result not valid")
   `GTG_ASSERT_SAME(a_iter_bound, clock, reset, state_ff == ST_ITER, cnt_ff < gtg_pkg::ITER_W'(gtg_pkg::LOOP_STEPS), "iteration count overrun")

endmodule
`default_nettype wire

>>> sv/go_to_goal_pi_controller.sv
// Top level of the go-to-goal PI controller: register port, controller
// and datapath. Depends on gtg_pkg, gtg_ctrl and gtg_dp.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  op, pos_x, pos_y, heading
//   rsp      out        rsp_valid/rsp_stall  linear_speed, turn_rate
//   csr      in/out     APB, pready = 1      four gain/standoff registers
//
// An own-pose request loads the pose and leaves the controller idle. A goal
// request runs the 17-step root/CORDIC loop, a heading-error wrap where needed
// and the shared multiplier; the next request can be taken in the same
// cycle as its result appears. Synchronous active-high reset; no clearing pass.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the next result waits until that register is free.
`default_nettype none
module go_to_goal_pi_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_op,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [14:0] req_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_linear_speed,
   output logic signed [15:0]      rsp_turn_rate,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [14:0] standoff_ff;
   logic [15:0] speed_gain_ff, integral_gain_ff, turn_gain_ff;
   logic        csr_write;
   gtg_pkg::reg_addr_type  reg_addr;
   gtg_pkg::dp_cmd_type    cmd;
   gtg_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_addr   = gtg_pkg::reg_addr_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         standoff_ff      <= 15'd256;
         speed_gain_ff    <= 16'd8192;
         integral_gain_ff <= 16'd164;
         turn_gain_ff     <= 16'd11469;
      end else if (csr_write) begin
         case (reg_addr)
            gtg_pkg::REG_STANDOFF: standoff_ff      <= csr_pwdata[14:0];
            gtg_pkg::REG_SPEED:    speed_gain_ff    <= csr_pwdata[15:0];
            gtg_pkg::REG_INTEGRAL: integral_gain_ff <= csr_pwdata[15:0];
            gtg_pkg::REG_TURN:     turn_gain_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_addr)
         gtg_pkg::REG_STANDOFF: csr_prdata = {17'b0, standoff_ff};
         gtg_pkg::REG_SPEED:    csr_prdata = {16'b0, speed_gain_ff};
         gtg_pkg::REG_INTEGRAL: csr_prdata = {16'b0, integral_gain_ff};
         gtg_pkg::REG_TURN:     csr_prdata = {16'b0, turn_gain_ff};
         default:               csr_prdata = '0;
      endcase
   end

   gtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   gtg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_heading       (req_heading),
      .standoff_distance (standoff_ff),
      .speed_gain        (speed_gain_ff),
      .integral_gain     (integral_gain_ff),
      .turn_gain         (turn_gain_ff),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_turn_rate     (rsp_turn_rate)
   );

endmodule
`default_nettype wire
